@@ design/sgi_pkg.sv @@
// Shared widths, payload types and queue types for the segment intersection core.
package sgi_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;          // coordinate difference
    localparam int PROD_W     = 2 * DIFF_W;              // one cross-product term
    localparam int CROSS_W    = 2 * COORD_BITS + 3;      // top, utop, bottom
    localparam int MAG_W      = 2 * COORD_BITS + 2;      // |top|, |bottom|
    localparam int NUM_W      = 3 * COORD_BITS + 3;      // |top|*|delta| and divider remainder
    localparam int QB_W       = COORD_BITS + 1;          // quotient bits kept
    localparam int DIV_STAGES = QB_W;
    localparam int QDEPTH     = 8;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = QPTR_W + 1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_start_x;
        logic signed [COORD_BITS-1:0] first_start_y;
        logic signed [COORD_BITS-1:0] first_end_x;
        logic signed [COORD_BITS-1:0] first_end_y;
        logic signed [COORD_BITS-1:0] second_start_x;
        logic signed [COORD_BITS-1:0] second_start_y;
        logic signed [COORD_BITS-1:0] second_end_x;
        logic signed [COORD_BITS-1:0] second_end_y;
    } t_in;

    typedef struct packed {
        logic                         hit;
        logic                         parallel;
        logic signed [COORD_BITS-1:0] cross_x;
        logic signed [COORD_BITS-1:0] cross_y;
    } t_out;

    // Classified job handed from the front part to the back part.
    typedef struct packed {
        logic                         hit;
        logic                         par;
        logic                         neg_x;
        logic                         neg_y;
        logic [MAG_W-1:0]             top_mag;
        logic [MAG_W-1:0]             bot_mag;
        logic [COORD_BITS-1:0]        ex_mag;
        logic [COORD_BITS-1:0]        ey_mag;
        logic signed [COORD_BITS-1:0] x1;
        logic signed [COORD_BITS-1:0] y1;
    } t_job;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              not_empty;
    } t_q_stat;

endpackage

@@ design/sgi_front.sv @@
// Front part: differences, cross products, hit/parallel classification.
module sgi_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  sgi_pkg::t_in    i_in_data,
    input  sgi_pkg::t_q_stat i_q_stat,
    output logic            o_push,
    output sgi_pkg::t_job   o_push_data
);
    localparam int C  = sgi_pkg::COORD_BITS;
    localparam int DW = sgi_pkg::DIFF_W;
    localparam int PW = sgi_pkg::PROD_W;
    localparam int CW = sgi_pkg::CROSS_W;
    localparam int MW = sgi_pkg::MAG_W;
    localparam int OW = sgi_pkg::QCNT_W + 1;

    logic r_v1, r_v2, r_v3;
    logic signed [DW-1:0] r_ex, r_ey, r_dx, r_dy, r_wx, r_wy;
    logic signed [C-1:0]  r_x1_1, r_y1_1, r_x1_2, r_y1_2, r_x1_3, r_y1_3;
    logic signed [DW-1:0] r_ex2, r_ey2, r_ex3, r_ey3;
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [CW-1:0] r_top, r_utop, r_bot;
    logic [OW-1:0]        w_occ;
    logic                 w_par;

    function automatic logic f_in_unit(input logic signed [CW-1:0] num,
                                       input logic signed [CW-1:0] den);
        if (den < 0) begin
            f_in_unit = (num <= 0) && (num >= den);
        end else begin
            f_in_unit = (num >= 0) && (num <= den);
        end
    endfunction

    // Hold off new items once the queue plus in-flight stages could overflow.
    assign w_occ = OW'(i_q_stat.count) + OW'(r_v1) + OW'(r_v2) + OW'(r_v3);
    assign o_in_ready = (w_occ < OW'(sgi_pkg::QDEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_in_valid && o_in_ready;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ex   <= DW'(i_in_data.first_end_x) - DW'(i_in_data.first_start_x);
        r_ey   <= DW'(i_in_data.first_end_y) - DW'(i_in_data.first_start_y);
        r_dx   <= DW'(i_in_data.second_end_x) - DW'(i_in_data.second_start_x);
        r_dy   <= DW'(i_in_data.second_end_y) - DW'(i_in_data.second_start_y);
        r_wx   <= DW'(i_in_data.first_start_x) - DW'(i_in_data.second_start_x);
        r_wy   <= DW'(i_in_data.first_start_y) - DW'(i_in_data.second_start_y);
        r_x1_1 <= i_in_data.first_start_x;
        r_y1_1 <= i_in_data.first_start_y;

        r_p0   <= r_dx * r_wy;
        r_p1   <= r_dy * r_wx;
        r_p2   <= r_ex * r_wy;
        r_p3   <= r_ey * r_wx;
        r_p4   <= r_dy * r_ex;
        r_p5   <= r_dx * r_ey;
        r_ex2  <= r_ex;
        r_ey2  <= r_ey;
        r_x1_2 <= r_x1_1;
        r_y1_2 <= r_y1_1;

        r_top  <= CW'(r_p0) - CW'(r_p1);
        r_utop <= CW'(r_p2) - CW'(r_p3);
        r_bot  <= CW'(r_p4) - CW'(r_p5);
        r_ex3  <= r_ex2;
        r_ey3  <= r_ey2;
        r_x1_3 <= r_x1_2;
        r_y1_3 <= r_y1_2;
    end

    assign w_par  = (r_bot == '0);
    assign o_push = r_v3;

    always_comb begin
        o_push_data.par     = w_par;
        o_push_data.hit     = !w_par && f_in_unit(r_top, r_bot) && f_in_unit(r_utop, r_bot);
        o_push_data.top_mag = r_top[CW-1] ? MW'(-r_top) : MW'(r_top);
        o_push_data.bot_mag = r_bot[CW-1] ? MW'(-r_bot) : MW'(r_bot);
        o_push_data.ex_mag  = r_ex3[DW-1] ? C'(-r_ex3) : C'(r_ex3);
        o_push_data.ey_mag  = r_ey3[DW-1] ? C'(-r_ey3) : C'(r_ey3);
        o_push_data.neg_x   = r_ex3[DW-1] ^ r_top[CW-1] ^ r_bot[CW-1];
        o_push_data.neg_y   = r_ey3[DW-1] ^ r_top[CW-1] ^ r_bot[CW-1];
        o_push_data.x1      = r_x1_3;
        o_push_data.y1      = r_y1_3;
    end

endmodule

@@ design/sgi_fifo.sv @@
// Short job queue between the front and back parts.
module sgi_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sgi_pkg::t_job    i_push_data,
    input  logic             i_pop,
    output sgi_pkg::t_job    o_pop_data,
    output sgi_pkg::t_q_stat o_stat
);
    localparam int PTW = sgi_pkg::QPTR_W;
    localparam int CNW = sgi_pkg::QCNT_W;

    sgi_pkg::t_job   r_mem [sgi_pkg::QDEPTH];
    logic [PTW-1:0]  r_wr, r_rd;
    logic [CNW-1:0]  r_cnt, n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CNW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    assign o_pop_data       = r_mem[r_rd];
    assign o_stat.count     = r_cnt;
    assign o_stat.not_empty = (r_cnt != '0);

endmodule

@@ design/sgi_back.sv @@
// Back part: interpolation products, pipelined restoring divide, saturation, output register.
module sgi_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sgi_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    input  sgi_pkg::t_job    i_pop_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output sgi_pkg::t_out    o_out_data
);
    localparam int C  = sgi_pkg::COORD_BITS;
    localparam int MW = sgi_pkg::MAG_W;
    localparam int NW = sgi_pkg::NUM_W;
    localparam int QB = sgi_pkg::QB_W;
    localparam int DS = sgi_pkg::DIV_STAGES;
    localparam int VW = C + 3;

    typedef struct packed {
        logic                hit;
        logic                par;
        logic                neg_x;
        logic                neg_y;
        logic                ovf_x;
        logic                ovf_y;
        logic [NW-1:0]       rem_x;
        logic [NW-1:0]       rem_y;
        logic [MW-1:0]       den;
        logic [QB-1:0]       q_x;
        logic [QB-1:0]       q_y;
        logic signed [C-1:0] x1;
        logic signed [C-1:0] y1;
    } t_bst;

    logic          w_en;
    logic          r_mv;
    t_bst          r_m;
    logic          r_dv_v [DS+1];
    t_bst          r_dv   [DS+1];
    t_bst          n_dv   [DS+1];
    logic          r_ov;
    sgi_pkg::t_out r_out;

    function automatic logic [C-1:0] f_fin(input logic signed [C-1:0] a, input logic neg,
                                           input logic ovf, input logic [QB-1:0] q);
        logic [QB:0]          mag;
        logic signed [VW-1:0] v;
        mag = ovf ? {1'b1, {QB{1'b0}}} : {1'b0, q};
        if (neg) begin
            v = VW'(a) - VW'(mag);
        end else begin
            v = VW'(a) + VW'(mag);
        end
        if (v[VW-1:C-1] != {(VW-C+1){v[VW-1]}}) begin
            f_fin = v[VW-1] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
        end else begin
            f_fin = v[C-1:0];
        end
    endfunction

    // Advance the whole back pipeline whenever the output register frees up.
    assign w_en  = !r_ov || i_out_ready;
    assign o_pop = w_en && i_q_stat.not_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
            r_ov <= 1'b0;
            for (int i = 0; i <= DS; i++) begin
                r_dv_v[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_mv      <= o_pop;
            r_dv_v[0] <= r_mv;
            for (int i = 1; i <= DS; i++) begin
                r_dv_v[i] <= r_dv_v[i-1];
            end
            r_ov <= r_dv_v[DS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m.hit   <= i_pop_data.hit;
            r_m.par   <= i_pop_data.par;
            r_m.neg_x <= i_pop_data.neg_x;
            r_m.neg_y <= i_pop_data.neg_y;
            r_m.ovf_x <= 1'b0;
            r_m.ovf_y <= 1'b0;
            r_m.rem_x <= NW'(i_pop_data.top_mag) * NW'(i_pop_data.ex_mag);
            r_m.rem_y <= NW'(i_pop_data.top_mag) * NW'(i_pop_data.ey_mag);
            r_m.den   <= i_pop_data.bot_mag;
            r_m.q_x   <= '0;
            r_m.q_y   <= '0;
            r_m.x1    <= i_pop_data.x1;
            r_m.y1    <= i_pop_data.y1;
        end
    end

    // Flag quotients that reach 2^(C+1); those saturate anyway.
    always_comb begin
        n_dv[0]       = r_m;
        n_dv[0].ovf_x = r_m.rem_x >= (NW'(r_m.den) << QB);
        n_dv[0].ovf_y = r_m.rem_y >= (NW'(r_m.den) << QB);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv[0] <= n_dv[0];
        end
    end

    for (genvar gi = 0; gi < DS; gi++) begin : g_div
        localparam int K = QB - 1 - gi;
        logic [NW-1:0] w_sub;
        logic          w_ge_x, w_ge_y;

        assign w_sub  = NW'(r_dv[gi].den) << K;
        assign w_ge_x = r_dv[gi].rem_x >= w_sub;
        assign w_ge_y = r_dv[gi].rem_y >= w_sub;

        always_comb begin
            n_dv[gi+1] = r_dv[gi];
            if (w_ge_x) begin
                n_dv[gi+1].rem_x  = r_dv[gi].rem_x - w_sub;
                n_dv[gi+1].q_x[K] = 1'b1;
            end
            if (w_ge_y) begin
                n_dv[gi+1].rem_y  = r_dv[gi].rem_y - w_sub;
                n_dv[gi+1].q_y[K] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv[gi+1] <= n_dv[gi+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.hit      <= r_dv[DS].hit;
            r_out.parallel <= r_dv[DS].par;
            if (r_dv[DS].par) begin
                r_out.cross_x <= r_dv[DS].x1;
                r_out.cross_y <= r_dv[DS].y1;
            end else begin
                r_out.cross_x <= f_fin(r_dv[DS].x1, r_dv[DS].neg_x, r_dv[DS].ovf_x,
                                       r_dv[DS].q_x);
                r_out.cross_y <= f_fin(r_dv[DS].y1, r_dv[DS].neg_y, r_dv[DS].ovf_y,
                                       r_dv[DS].q_y);
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

@@ design/segment_intersection_2d_core.sv @@
// Top level of the 2D segment intersection core: front, job queue, back.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (two segments, XY)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (hit, parallel, XY)
//
// One transaction per cycle sustained while the output does not stall; the restoring divider
// resolves one quotient bit per stage (COORD_BITS+1 stages).
// The front takes 3 register stages, then the job is written into the queue of 8 jobs, then
// 1 multiply stage, 1 range stage, the divider stages and the output register.
// Reset clears all valid flags and the queue pointers; payload registers are not reset.
// An output stall freezes the back pipeline; the queue absorbs front work, and
// o_in_ready drops once queued plus in-flight front transactions reach the queue depth.
module segment_intersection_2d_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sgi_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sgi_pkg::t_out o_out_data
);
    logic             w_push, w_pop;
    sgi_pkg::t_job    w_push_data, w_pop_data;
    sgi_pkg::t_q_stat w_q_stat;

    // Classify each transaction and queue it as a job.
    sgi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // Decouple the two halves so each can stall on its own.
    sgi_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_stat      (w_q_stat)
    );

    // Interpolate the crossing point and drive the output register.
    sgi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (w_q_stat),
        .o_pop       (w_pop),
        .i_pop_data  (w_pop_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // The credit check must never let the front push into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && !w_pop &&
          (w_q_stat.count == sgi_pkg::QCNT_W'(sgi_pkg::QDEPTH))))
        else $error("job queue overflow");

    // A full queue must hold off the input.
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_stat.count == sgi_pkg::QCNT_W'(sgi_pkg::QDEPTH)) |-> !o_in_ready)
        else $error("input accepted with full queue");

    // Parallel segments never report a hit.
    a_par_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.parallel) |-> !o_out_data.hit)
        else $error("hit reported for parallel segments");

endmodule

@@ test/segment_intersection_checker.sv @@
// Channel monitor, crossing predictor and result comparator for the segment intersection core.
module segment_intersection_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  sgi_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  sgi_pkg::t_out i_out_data,
    output int            o_fail_count,
    output int            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] t_wide;

    localparam t_wide QUOT_CAP = t_wide'(1) <<< 40;
    localparam t_wide COORD_MAX = t_wide'((1 <<< (sgi_pkg::COORD_BITS - 1)) - 1);
    localparam t_wide COORD_MIN = -COORD_MAX - 1;

    sgi_pkg::t_out expected_results[$];

    function automatic t_wide mag(t_wide v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic bit param_in_unit(t_wide num, t_wide den);
        if (den < 0)
            return (num <= 0) && (num >= den);
        return (num >= 0) && (num <= den);
    endfunction

    // Point on the first line at T = top/bot, truncated toward zero, then saturated.
    function automatic logic signed [sgi_pkg::COORD_BITS-1:0] interp_coord(
            t_wide a, t_wide b, t_wide top, t_wide bot);
        t_wide quot;
        t_wide v;
        bit    neg;
        quot = (mag(top) * mag(b - a)) / mag(bot);
        if (quot > QUOT_CAP)
            quot = QUOT_CAP;
        neg = (b < a) ^ (top < 0) ^ (bot < 0);
        v = neg ? a - quot : a + quot;
        if (v > COORD_MAX)
            v = COORD_MAX;
        if (v < COORD_MIN)
            v = COORD_MIN;
        return v[sgi_pkg::COORD_BITS-1:0];
    endfunction

    function automatic sgi_pkg::t_out predict_crossing(sgi_pkg::t_in p);
        t_wide x1, y1, x2, y2, x3, y3, x4, y4;
        t_wide ex, ey, dx, dy, wx, wy;
        t_wide top, utop, bot;
        sgi_pkg::t_out r;
        x1 = p.first_start_x;  y1 = p.first_start_y;
        x2 = p.first_end_x;    y2 = p.first_end_y;
        x3 = p.second_start_x; y3 = p.second_start_y;
        x4 = p.second_end_x;   y4 = p.second_end_y;
        ex = x2 - x1; ey = y2 - y1;
        dx = x4 - x3; dy = y4 - y3;
        wx = x1 - x3; wy = y1 - y3;
        top  = dx * wy - dy * wx;
        utop = ex * wy - ey * wx;
        bot  = dy * ex - dx * ey;
        r.parallel = (bot == 0);
        r.hit      = 1'b0;
        r.cross_x  = p.first_start_x;
        r.cross_y  = p.first_start_y;
        if (!r.parallel) begin
            r.hit     = param_in_unit(top, bot) && param_in_unit(utop, bot);
            r.cross_x = interp_coord(x1, x2, top, bot);
            r.cross_y = interp_coord(y1, y2, top, bot);
        end
        return r;
    endfunction

    initial o_fail_count = 0;
    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        sgi_pkg::t_out want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                expected_results.push_back(predict_crossing(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want !== i_out_data) begin
                        $display("%0t: mismatch hit exp %0b act %0b, parallel exp %0b act %0b",
                                 $time, want.hit, i_out_data.hit, want.parallel,
                                 i_out_data.parallel);
                        $display("%0t:   cross_x exp %0d act %0d, cross_y exp %0d act %0d",
                                 $time, want.cross_x, i_out_data.cross_x, want.cross_y,
                                 i_out_data.cross_y);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

@@ test/testbench.sv @@
// Top of the segment intersection regression: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PAIRS = 450;
    localparam logic signed [15:0] CMAX = 16'sh7fff;
    localparam logic signed [15:0] CMIN = -16'sh8000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    sgi_pkg::t_in  i_in_data = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    sgi_pkg::t_out o_out_data;
    int            fail_count;
    int            pending;
    bit            idle_enable = 1'b1;

    always #2 i_clk = ~i_clk;

    segment_intersection_2d_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    segment_intersection_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Stall the result side about 21 percent of the time, except during the full-throughput stretch.
    always @(posedge i_clk)
        i_out_ready <= !(idle_enable && ($urandom_range(99) < 21));

    // Send one segment pair: maybe idle first, then hold valid until accepted.
    task automatic send_pair(input sgi_pkg::t_in pair);
        while (idle_enable && ($urandom_range(99) < 21)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= pair;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    function automatic sgi_pkg::t_in make_pair(logic signed [15:0] ax, logic signed [15:0] ay,
                                               logic signed [15:0] bx, logic signed [15:0] by,
                                               logic signed [15:0] cx, logic signed [15:0] cy,
                                               logic signed [15:0] dx, logic signed [15:0] dy);
        sgi_pkg::t_in p;
        p.first_start_x = ax;  p.first_start_y = ay;
        p.first_end_x = bx;    p.first_end_y = by;
        p.second_start_x = cx; p.second_start_y = cy;
        p.second_end_x = dx;   p.second_end_y = dy;
        return p;
    endfunction

    function automatic logic signed [15:0] near_coord(int span);
        return 16'($signed($urandom_range(2 * span)) - span);
    endfunction

    // Mostly pairs in a small box that often cross; the rest parallel, touching,
    // degenerate, extreme or fully random.
    function automatic sgi_pkg::t_in random_pair();
        sgi_pkg::t_in p;
        int  span;
        logic signed [15:0] ox, oy;
        span = ($urandom_range(3) == 0) ? 32767 : $urandom_range(4, 2000);
        p = make_pair(near_coord(span), near_coord(span), near_coord(span),
                      near_coord(span), near_coord(span), near_coord(span),
                      near_coord(span), near_coord(span));
        case ($urandom_range(9))
            0: p = sgi_pkg::t_in'({$urandom, $urandom, $urandom, $urandom});
            1: begin
                // parallel: second is the first shifted
                ox = near_coord(200); oy = near_coord(200);
                p.second_start_x = p.first_start_x + ox;
                p.second_start_y = p.first_start_y + oy;
                p.second_end_x = p.first_end_x + ox;
                p.second_end_y = p.first_end_y + oy;
            end
            2: begin
                // touching at an endpoint
                if ($urandom_range(1)) begin
                    p.second_start_x = p.first_end_x;
                    p.second_start_y = p.first_end_y;
                end else begin
                    p.second_end_x = p.first_start_x;
                    p.second_end_y = p.first_start_y;
                end
            end
            3: begin
                p.first_end_x = p.first_start_x;
                p.first_end_y = p.first_start_y;
            end
            4: begin
                p.first_start_x = $urandom_range(1) ? CMAX : CMIN;
                p.second_end_y = $urandom_range(1) ? CMAX : CMIN;
            end
            default: ;
        endcase
        return p;
    endfunction

    initial begin
        int waited;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: crossing, touching ends, parallel, collinear, degenerate, extremes.
        send_pair(make_pair(0, 0, 160, 160, 0, 160, 160, 0));
        send_pair(make_pair(0, 0, 160, 0, 160, -16, 160, 16));
        send_pair(make_pair(0, 0, 160, 0, 0, -16, 0, 16));
        send_pair(make_pair(0, 0, 160, 0, 0, 16, 160, 16));
        send_pair(make_pair(0, 0, 160, 0, 32, 0, 320, 0));
        send_pair(make_pair(5, 5, 5, 5, 0, 0, 16, 16));
        send_pair(make_pair(7, 9, 7, 9, 7, 9, 7, 9));
        send_pair(make_pair(0, 0, 16, 0, 400, -16, 400, 16));
        send_pair(make_pair(0, 0, 16, 1, -100, 0, 100, 0));
        send_pair(make_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN));
        send_pair(make_pair(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX));
        send_pair(make_pair(CMIN, CMIN, CMIN + 1, CMIN, CMAX, CMIN, CMAX, CMAX));
        send_pair(make_pair(CMAX, CMAX, CMAX - 1, CMAX, CMIN, CMAX, CMIN, CMIN));
        send_pair(make_pair(CMIN, 0, CMIN, 1, CMIN, CMAX, CMAX, CMAX - 1));
        send_pair(make_pair(0, 0, 1, 1, CMAX, CMIN, CMAX - 1, CMIN + 1));
        send_pair(make_pair(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
        send_pair(make_pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
        send_pair(make_pair(-1, -1, -1, -1, 0, 0, 0, 0));
        send_pair(make_pair(0, 0, 160, 160, 160, 0, 80, 80));

        // Random pairs, with a stretch at full throughput in the middle.
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            idle_enable = !(n >= 180 && n < 280);
            send_pair(random_pair());
        end
        idle_enable = 1'b1;
        i_in_valid <= 1'b0;

        // Drain, then give the pipeline its latency to flush strays.
        waited = 0;
        while (pending != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("segment_intersection_2d_core regression: pass");
        else
            $display("segment_intersection_2d_core regression: fail");
        $finish;
    end

    // Watchdog: end a hung run.
    initial begin
        #400000;
        $display("segment_intersection_2d_core regression: fail");
        $finish;
    end
endmodule

@@ filelist.f @@
design/sgi_pkg.sv
design/sgi_front.sv
design/sgi_fifo.sv
design/sgi_back.sv
design/segment_intersection_2d_core.sv
test/segment_intersection_checker.sv
test/testbench.sv
